/* design/assert_macros.svh */
// Assertion macros for the design files; flrs_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the condition holds at an edge, the check must hold at the same edge.
`define ASSERT_SAME(label, clk, rst, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error("assertion failed");

// When the condition holds at an edge, the check must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error("assertion failed");

`endif

/* design/flrs_pkg.sv */
package flrs_pkg;

  localparam int CODE_W    = 3;
  localparam int LEVEL_W   = 3;
  localparam int PERCENT_W = 7;
  localparam int STEP_W    = 2;

  localparam logic [1:0] CMD_LIGHT   = 2'd0;
  localparam logic [1:0] CMD_FAN     = 2'd1;
  localparam logic [1:0] CMD_SPEED   = 2'd2;
  localparam logic [1:0] CMD_PERCENT = 2'd3;

  localparam logic [CODE_W-1:0] CODE_NONE      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_LIGHT_ON  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_LIGHT_OFF = 3'd2;
  localparam logic [CODE_W-1:0] CODE_FAN_PLUS  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_FAN_MINUS = 3'd4;
  localparam logic [CODE_W-1:0] CODE_FAN_OFF   = 3'd5;

  localparam logic [LEVEL_W-1:0]   LEVEL_RESET   = 3'd1;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX     = 3'd4;
  localparam logic [PERCENT_W-1:0] PERCENT_RESET = 7'd25;
  localparam logic [PERCENT_W-1:0] PERCENT_STEP  = 7'd25;
  localparam logic [15:0]          PERCENT_MAX   = 16'd100;
  localparam logic [15:0]          SPEED2_FROM   = 16'd38;
  localparam logic [15:0]          SPEED3_FROM   = 16'd63;
  localparam logic [15:0]          SPEED4_FROM   = 16'd88;

  // One classified command: which code to send, how many extra repeats,
  // and the state to report with every result.
  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [STEP_W-1:0]    steps;
    logic                 accepted;
    logic                 light;
    logic                 fan;
    logic [LEVEL_W-1:0]   level;
    logic [PERCENT_W-1:0] percent;
  } plan_t;

endpackage

/* design/flrs_front.sv */
module flrs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [15:0]          value,
  output logic                 push,
  output flrs_pkg::plan_t      plan,
  input  logic                 q_full
);

  logic                              light;
  logic                              fan;
  logic [flrs_pkg::LEVEL_W-1:0]      level;
  logic [flrs_pkg::PERCENT_W-1:0]    percent;

  logic                              drive_en;
  logic                              want_on;
  logic [flrs_pkg::LEVEL_W-1:0]      want_level;
  logic [flrs_pkg::LEVEL_W-1:0]      from_level;
  logic [flrs_pkg::LEVEL_W-1:0]      diff;
  logic [flrs_pkg::LEVEL_W-1:0]      mapped;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    plan.code     = flrs_pkg::CODE_NONE;
    plan.steps    = '0;
    plan.accepted = 1'b1;
    plan.light    = light;
    plan.fan      = fan;
    plan.level    = level;
    plan.percent  = percent;
    drive_en      = 1'b0;
    want_on       = 1'b0;
    want_level    = level;
    from_level    = '0;
    diff          = '0;

    if (value < flrs_pkg::SPEED2_FROM) begin
      mapped = 3'd1;
    end else if (value < flrs_pkg::SPEED3_FROM) begin
      mapped = 3'd2;
    end else if (value < flrs_pkg::SPEED4_FROM) begin
      mapped = 3'd3;
    end else begin
      mapped = flrs_pkg::LEVEL_MAX;
    end

    case (command)
      flrs_pkg::CMD_LIGHT: begin
        if (value > 16'd1) begin
          plan.accepted = 1'b0;
        end else begin
          plan.light = value[0];
          plan.code  = value[0] ? flrs_pkg::CODE_LIGHT_ON : flrs_pkg::CODE_LIGHT_OFF;
        end
      end
      flrs_pkg::CMD_FAN: begin
        if (value > 16'd1) begin
          plan.accepted = 1'b0;
        end else begin
          drive_en   = 1'b1;
          want_on    = value[0];
          want_level = level;
        end
      end
      flrs_pkg::CMD_SPEED: begin
        if (value == 16'd0 || value > 16'({flrs_pkg::LEVEL_MAX})) begin
          plan.accepted = 1'b0;
        end else begin
          plan.percent = 7'(value[flrs_pkg::LEVEL_W-1:0]) * flrs_pkg::PERCENT_STEP;
          drive_en     = 1'b1;
          want_on      = fan;
          want_level   = value[flrs_pkg::LEVEL_W-1:0];
        end
      end
      flrs_pkg::CMD_PERCENT: begin
        if (value == 16'd0 || value > flrs_pkg::PERCENT_MAX) begin
          plan.accepted = 1'b0;
        end else begin
          plan.percent = value[flrs_pkg::PERCENT_W-1:0];
          drive_en     = (level != mapped);
          want_on      = fan;
          want_level   = mapped;
        end
      end
      default: begin
        plan.accepted = 1'b0;
      end
    endcase

    if (plan.accepted && drive_en) begin
      plan.level = want_level;
      if (want_on) begin
        // A fan that was off is taken to start from speed zero.
        from_level = fan ? level : '0;
        plan.fan   = 1'b1;
        if (want_level > from_level) begin
          diff       = want_level - from_level;
          plan.code  = flrs_pkg::CODE_FAN_PLUS;
          plan.steps = flrs_pkg::STEP_W'(diff - 3'd1);
        end else if (want_level < from_level) begin
          diff       = from_level - want_level;
          plan.code  = flrs_pkg::CODE_FAN_MINUS;
          plan.steps = flrs_pkg::STEP_W'(diff - 3'd1);
        end
      end else if (fan) begin
        plan.fan  = 1'b0;
        plan.code = flrs_pkg::CODE_FAN_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light   <= 1'b0;
      fan     <= 1'b0;
      level   <= flrs_pkg::LEVEL_RESET;
      percent <= flrs_pkg::PERCENT_RESET;
    end else if (push) begin
      light   <= plan.light;
      fan     <= plan.fan;
      level   <= plan.level;
      percent <= plan.percent;
    end
  end

endmodule

/* design/flrs_queue.sv */
module flrs_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  flrs_pkg::plan_t push_plan,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output flrs_pkg::plan_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flrs_pkg::plan_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CW'(DEPTH));
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* design/flrs_back.sv */
`include "assert_macros.svh"

module flrs_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  flrs_pkg::plan_t                    head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [flrs_pkg::CODE_W-1:0]        remote_code,
  output logic                               last,
  output logic                               accepted,
  output logic                               light_is_on,
  output logic                               fan_is_on,
  output logic [flrs_pkg::LEVEL_W-1:0]       speed_now,
  output logic [flrs_pkg::PERCENT_W-1:0]     percent_now
);

  logic [flrs_pkg::STEP_W-1:0] step;
  logic                        fire;
  logic                        is_last;

  // The output register takes a new item whenever the queue holds one and the register is empty or being drained.
  assign fire    = q_valid && (!out_valid || out_ready);
  assign is_last = (step == head.steps);
  assign pop     = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        step      <= is_last ? '0 : step + flrs_pkg::STEP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      remote_code <= head.code;
      last        <= is_last;
      accepted    <= head.accepted;
      light_is_on <= head.light;
      fan_is_on   <= head.fan;
      speed_now   <= head.level;
      percent_now <= head.percent;
    end
  end

  `ASSERT_SAME(a_step_bounded, clk, rst, q_valid, step <= head.steps)
  `ASSERT_SAME(a_idle_step_zero, clk, rst, !q_valid, step == '0)
  `ASSERT_NEXT(a_pop_marks_last, clk, rst, pop, out_valid && last)
  `ASSERT_SAME(a_none_single, clk, rst, out_valid && remote_code == flrs_pkg::CODE_NONE, last)
  `ASSERT_SAME(a_reject_none, clk, rst, out_valid && !accepted,
               remote_code == flrs_pkg::CODE_NONE)

endmodule

/* design/fan_light_remote_sequencer.sv */
// Throughput: the back end emits one result per cycle while out_ready allows,
// one to four per command; the front takes a command per cycle while the
// command queue (QUEUE_DEPTH entries) has room.
// Reset (synchronous, active high): light off, fan off, speed 1, 25 percent,
// command queue and output register emptied.
module fan_light_remote_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [15:0]                        value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [flrs_pkg::CODE_W-1:0]        remote_code,
  output logic                               last,
  output logic                               accepted,
  output logic                               light_is_on,
  output logic                               fan_is_on,
  output logic [flrs_pkg::LEVEL_W-1:0]       speed_now,
  output logic [flrs_pkg::PERCENT_W-1:0]     percent_now
);

  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  flrs_pkg::plan_t plan;
  flrs_pkg::plan_t head;

  flrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .value    (value),
    .push     (push),
    .plan     (plan),
    .q_full   (q_full)
  );

  flrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (plan),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  flrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .remote_code (remote_code),
    .last        (last),
    .accepted    (accepted),
    .light_is_on (light_is_on),
    .fan_is_on   (fan_is_on),
    .speed_now   (speed_now),
    .percent_now (percent_now)
  );

endmodule

/* verif/fan_light_remote_sequencer_tb.sv */
`timescale 1ns / 100ps

module fan_light_remote_sequencer_tb;

  typedef struct packed {
    logic [flrs_pkg::CODE_W-1:0]    code;
    logic                           last;
    logic                           accepted;
    logic                           light;
    logic                           fan;
    logic [flrs_pkg::LEVEL_W-1:0]   level;
    logic [flrs_pkg::PERCENT_W-1:0] percent;
  } remote_result_t;

  class remote_scoreboard;
    remote_result_t                 awaited[$];
    logic [flrs_pkg::CODE_W-1:0]    code_run[$];
    logic                           light_on;
    logic                           fan_on;
    logic [flrs_pkg::LEVEL_W-1:0]   level;
    logic [flrs_pkg::PERCENT_W-1:0] percent;
    int                             fail_count;

    function new();
      light_on   = 1'b0;
      fan_on     = 1'b0;
      level      = flrs_pkg::LEVEL_RESET;
      percent    = flrs_pkg::PERCENT_RESET;
      fail_count = 0;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
    endtask

    // A fan that is off and stays off only remembers the new speed.
    // Switching on counts up from speed zero.
    function void steer_fan(logic want_on, logic [flrs_pkg::LEVEL_W-1:0] want_level);
      logic [flrs_pkg::LEVEL_W-1:0] from;
      if (!want_on && !fan_on) begin
        level = want_level;
        return;
      end
      if (want_on) begin
        from = fan_on ? level : '0;
        while (from < want_level) begin
          code_run.push_back(flrs_pkg::CODE_FAN_PLUS);
          from++;
        end
        while (from > want_level) begin
          code_run.push_back(flrs_pkg::CODE_FAN_MINUS);
          from--;
        end
        fan_on = 1'b1;
      end else begin
        fan_on = 1'b0;
        code_run.push_back(flrs_pkg::CODE_FAN_OFF);
      end
      level = want_level;
    endfunction

    function void note_command(logic [1:0] cmd, logic [15:0] val);
      logic                         ok;
      logic [flrs_pkg::LEVEL_W-1:0] target;
      remote_result_t               res;
      int                           n;
      ok = 1'b1;
      code_run.delete();
      case (cmd)
        flrs_pkg::CMD_LIGHT: begin
          if (val > 16'd1) begin
            ok = 1'b0;
          end else begin
            light_on = val[0];
            code_run.push_back(light_on ? flrs_pkg::CODE_LIGHT_ON
                                        : flrs_pkg::CODE_LIGHT_OFF);
          end
        end
        flrs_pkg::CMD_FAN: begin
          if (val > 16'd1) ok = 1'b0;
          else steer_fan(val[0], level);
        end
        flrs_pkg::CMD_SPEED: begin
          if (val < 16'd1 || val > 16'(flrs_pkg::LEVEL_MAX)) begin
            ok = 1'b0;
          end else begin
            percent = flrs_pkg::PERCENT_W'(val * flrs_pkg::PERCENT_STEP);
            steer_fan(fan_on, flrs_pkg::LEVEL_W'(val));
          end
        end
        default: begin
          if (val < 16'd1 || val > flrs_pkg::PERCENT_MAX) begin
            ok = 1'b0;
          end else begin
            if (val < flrs_pkg::SPEED2_FROM) target = 3'd1;
            else if (val < flrs_pkg::SPEED3_FROM) target = 3'd2;
            else if (val < flrs_pkg::SPEED4_FROM) target = 3'd3;
            else target = 3'd4;
            percent = flrs_pkg::PERCENT_W'(val);
            if (level != target) steer_fan(fan_on, target);
          end
        end
      endcase
      if (code_run.size() == 0) code_run.push_back(flrs_pkg::CODE_NONE);
      n = code_run.size();
      for (int k = 0; k < n; k++) begin
        res.code     = code_run[k];
        res.last     = (k == n - 1);
        res.accepted = ok;
        res.light    = light_on;
        res.fan      = fan_on;
        res.level    = level;
        res.percent  = percent;
        awaited.push_back(res);
      end
    endfunction

    task check_result(remote_result_t got);
      remote_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with code %0d but nothing awaited", got.code));
        return;
      end
      want = awaited.pop_front();
      if (got.code !== want.code)
        report($sformatf("remote_code %0d, expected %0d", got.code, want.code));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %0b, expected %0b", got.accepted, want.accepted));
      if (got.light !== want.light)
        report($sformatf("light_is_on %0b, expected %0b", got.light, want.light));
      if (got.fan !== want.fan)
        report($sformatf("fan_is_on %0b, expected %0b", got.fan, want.fan));
      if (got.level !== want.level)
        report($sformatf("speed_now %0d, expected %0d", got.level, want.level));
      if (got.percent !== want.percent)
        report($sformatf("percent_now %0d, expected %0d", got.percent, want.percent));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     command = flrs_pkg::CMD_LIGHT;
  logic [15:0]                    value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [flrs_pkg::CODE_W-1:0]    remote_code;
  logic                           last;
  logic                           accepted;
  logic                           light_is_on;
  logic                           fan_is_on;
  logic [flrs_pkg::LEVEL_W-1:0]   speed_now;
  logic [flrs_pkg::PERCENT_W-1:0] percent_now;

  logic              calm = 1'b0;
  remote_scoreboard  sb = new();

  fan_light_remote_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .remote_code(remote_code),
    .last(last),
    .accepted(accepted),
    .light_is_on(light_is_on),
    .fan_is_on(fan_is_on),
    .speed_now(speed_now),
    .percent_now(percent_now)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{remote_code, last, accepted, light_is_on, fan_is_on,
                        speed_now, percent_now});
  end

  // Holds the item until the edge that takes it, then tells the scoreboard.
  task send_command(logic [1:0] cmd, logic [15:0] val);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd, val);
  endtask

  // Mostly values the block acts on; the rest are full-range noise and fixed edge values, most of them rejects.
  function logic [15:0] pick_value(logic [1:0] cmd);
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      case (cmd)
        flrs_pkg::CMD_LIGHT, flrs_pkg::CMD_FAN: return 16'($urandom_range(1));
        flrs_pkg::CMD_SPEED:                    return 16'($urandom_range(4, 1));
        default:                                return 16'($urandom_range(100, 1));
      endcase
    end
    if (roll < 90) return 16'($urandom_range(65535));
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'd2;
      2:       return 16'd5;
      default: return 16'd101;
    endcase
  endfunction

  initial begin
    logic [1:0] cmd;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(flrs_pkg::CMD_LIGHT, 16'd1);
    send_command(flrs_pkg::CMD_LIGHT, 16'd0);
    send_command(flrs_pkg::CMD_LIGHT, 16'd2);
    send_command(flrs_pkg::CMD_FAN, 16'd0);
    send_command(flrs_pkg::CMD_SPEED, 16'd4);
    send_command(flrs_pkg::CMD_FAN, 16'd1);
    send_command(flrs_pkg::CMD_SPEED, 16'd1);
    send_command(flrs_pkg::CMD_SPEED, 16'd0);
    send_command(flrs_pkg::CMD_SPEED, 16'd5);
    send_command(flrs_pkg::CMD_PERCENT, 16'd0);
    send_command(flrs_pkg::CMD_PERCENT, 16'd101);
    send_command(flrs_pkg::CMD_PERCENT, 16'hFFFF);
    send_command(flrs_pkg::CMD_PERCENT, 16'd100);
    send_command(flrs_pkg::CMD_PERCENT, 16'd88);
    send_command(flrs_pkg::CMD_PERCENT, 16'd87);
    send_command(flrs_pkg::CMD_PERCENT, 16'd63);
    send_command(flrs_pkg::CMD_PERCENT, 16'd62);
    send_command(flrs_pkg::CMD_PERCENT, 16'd38);
    send_command(flrs_pkg::CMD_PERCENT, 16'd37);
    send_command(flrs_pkg::CMD_PERCENT, 16'd1);
    send_command(flrs_pkg::CMD_FAN, 16'd1);
    send_command(flrs_pkg::CMD_FAN, 16'd2);
    send_command(flrs_pkg::CMD_FAN, 16'd0);
    send_command(flrs_pkg::CMD_PERCENT, 16'd50);
    send_command(flrs_pkg::CMD_FAN, 16'd1);

    for (int i = 0; i < 75; i++) begin
      if (i == 40) calm <= 1'b1;
      if (i == 70) calm <= 1'b0;
      cmd = 2'($urandom_range(3));
      send_command(cmd, pick_value(cmd));
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/flrs_pkg.sv
design/flrs_front.sv
design/flrs_queue.sv
design/flrs_back.sv
design/fan_light_remote_sequencer.sv
verif/fan_light_remote_sequencer_tb.sv
